### rtl/acpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acpp_pkg;

  localparam int PAYLOAD_SAMPLES = 32;
  localparam int HALF_SPAN       = 32;
  localparam int HALF_W          = $clog2(HALF_SPAN);
  localparam int ADDR_W          = HALF_W + 1;
  localparam int STORE_DEPTH     = 2 * HALF_SPAN;
  localparam int CNT_W           = $clog2(HALF_SPAN + 1);

  localparam logic [7:0] CLIP_RESET = 8'd160;
  localparam logic [7:0] MID_SCALE  = 8'd128;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic start_drain;
    logic issue_rd;
    logic move_byte;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic mem_v;
    logic mem_last;
    logic rd_done;
    logic ready_other;
  } ctrl_sts_t;

  function automatic logic [7:0] clip_sample(input logic [7:0] s, input logic [7:0] level);
    logic [7:0] lo;
    logic [7:0] res;
    lo  = ~level;
    res = s;
    if ((s < lo) && (s < MID_SCALE)) begin
      res = lo;
    end else if ((s > level) && (s > MID_SCALE)) begin
      res = level;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/acpp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module acpp_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire                     in_kind,
  output logic                    in_stall,
  input  wire acpp_pkg::ctrl_sts_t sts,
  output acpp_pkg::ctrl_cmd_t     cmd,
  output acpp_pkg::state_t        state
);
  import acpp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_xfer;

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.out_free && (in_kind == KIND_TICK) && sts.ready_other) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.mem_v && sts.out_free && sts.mem_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    in_xfer  = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall        = !sts.out_free;
        in_xfer         = in_valid && sts.out_free;
        cmd.take_sample = in_xfer && (in_kind == KIND_SAMPLE);
        cmd.start_drain = in_xfer && (in_kind == KIND_TICK) && sts.ready_other;
      end
      ST_DRAIN: begin
        cmd.move_byte = sts.mem_v && sts.out_free;
        // refill the read slot as it empties
        cmd.issue_rd  = !sts.rd_done && (!sts.mem_v || cmd.move_byte);
        cmd.finish    = cmd.move_byte && sts.mem_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/acpp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module acpp_datapath (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  [7:0]              in_sample,
  input  wire                     cfg_wr_en,
  input  wire  [7:0]              cfg_wr_data,
  input  wire                     out_stall,
  output logic                    out_valid,
  output logic                    out_is_payload,
  output logic [7:0]              out_monitor_sample,
  output logic [7:0]              out_payload_byte,
  output logic                    out_payload_last,
  input  wire acpp_pkg::ctrl_cmd_t cmd,
  output acpp_pkg::ctrl_sts_t     sts,
  output logic [1:0]              half_ready
);
  import acpp_pkg::*;

  logic [7:0]        store_mem [STORE_DEPTH];

  logic [7:0]        clip_level_r;
  logic              active_half_r;
  logic [HALF_W-1:0] fill_count_r;
  logic [HALF_W-1:0] fill_count_nxt;
  logic [1:0]        half_ready_r;
  logic [1:0]        half_ready_nxt;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic [7:0]        mem_q_r;
  logic              mem_last_r;
  logic              mem_v_r;
  logic              mem_v_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_is_payload_r;
  logic [7:0]        out_monitor_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic [7:0]        clipped;
  logic              half_full;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign clipped   = clip_sample(in_sample, clip_level_r);
  assign half_full = ((HALF_W + 1)'(fill_count_r) + 1'b1) >= (HALF_W + 1)'(PAYLOAD_SAMPLES);
  assign wr_addr   = {active_half_r, fill_count_r};
  assign rd_addr   = {~active_half_r, rd_cnt_r[HALF_W-1:0]};

  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.mem_v       = mem_v_r;
  assign sts.mem_last    = mem_last_r;
  assign sts.rd_done     = (rd_cnt_r == CNT_W'(PAYLOAD_SAMPLES));
  assign sts.ready_other = half_ready_r[~active_half_r];

  assign half_ready = half_ready_r;

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      store_mem[wr_addr] <= clipped;
    end
    if (cmd.issue_rd) begin
      mem_q_r    <= store_mem[rd_addr];
      mem_last_r <= (rd_cnt_r == CNT_W'(PAYLOAD_SAMPLES - 1));
    end
  end

  always_comb begin
    fill_count_nxt = fill_count_r;
    half_ready_nxt = half_ready_r;
    if (cmd.take_sample) begin
      if (half_full) begin
        fill_count_nxt = '0;
        half_ready_nxt[active_half_r] = 1'b1;
      end else begin
        fill_count_nxt = fill_count_r + 1'b1;
      end
    end
    // the drained half is the inactive one
    if (cmd.finish) begin
      half_ready_nxt[~active_half_r] = 1'b0;
    end
  end

  always_comb begin
    mem_v_nxt = mem_v_r;
    if (cmd.issue_rd) begin
      mem_v_nxt = 1'b1;
    end else if (cmd.move_byte) begin
      mem_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.take_sample || cmd.move_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_level_r  <= CLIP_RESET;
      active_half_r <= 1'b0;
      fill_count_r  <= '0;
      half_ready_r  <= '0;
      rd_cnt_r      <= '0;
      mem_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clip_level_r <= cfg_wr_data;
      end
      if (cmd.take_sample && half_full) begin
        active_half_r <= ~active_half_r;
      end
      fill_count_r <= fill_count_nxt;
      half_ready_r <= half_ready_nxt;
      if (cmd.start_drain) begin
        rd_cnt_r <= '0;
      end else if (cmd.issue_rd) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      mem_v_r     <= mem_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      out_is_payload_r <= 1'b0;
      out_monitor_r    <= clipped;
      out_byte_r       <= 8'd0;
      out_last_r       <= 1'b0;
    end else if (cmd.move_byte) begin
      out_is_payload_r <= 1'b1;
      out_monitor_r    <= 8'd0;
      out_byte_r       <= mem_q_r;
      out_last_r       <= mem_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_payload     = out_is_payload_r;
  assign out_monitor_sample = out_monitor_r;
  assign out_payload_byte   = out_byte_r;
  assign out_payload_last   = out_last_r;

endmodule

`default_nettype wire

### rtl/audio_clip_pingpong_packetizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Sample: monitor result registered, valid in the cycle after the transfer; one sample per
// cycle while the output is not stalled and no drain is running.
// Send tick with a ready half: the first payload byte passes the drain state, the read
// register and the output register, then one byte per cycle while the output is not
// stalled, through the single read port of the sample memory; input is held off while
// the drain runs. A tick with nothing ready is taken and dropped. Reset (rst_n low,
// synchronous): clip level 160, fill half 0, both halves empty.
module audio_clip_pingpong_packetizer (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_kind,
  input  wire  [7:0] in_sample,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_is_payload,
  output logic [7:0] out_monitor_sample,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_last,
  input  wire        cfg_wr_en,
  input  wire  [7:0] cfg_wr_data
);
  import acpp_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  state_t     state;
  logic [1:0] half_ready;

  acpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  acpp_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample          (in_sample),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_is_payload     (out_is_payload),
    .out_monitor_sample (out_monitor_sample),
    .out_payload_byte   (out_payload_byte),
    .out_payload_last   (out_payload_last),
    .cmd                (cmd),
    .sts                (sts),
    .half_ready         (half_ready)
  );

  a_read_slot_only_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mem_v |-> (state == ST_DRAIN))
    else $error("read data pending outside a drain");

  a_finish_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (((half_ready & ~$past(half_ready)) == 2'b00) && !sts.ready_other))
    else $error("drain finish did not update ready flags");

  a_drain_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_drain |-> sts.ready_other)
    else $error("drain started on a half that is not ready");

  a_last_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_payload && out_payload_last) |-> (state == ST_IDLE))
    else $error("last payload byte shown while the drain is still running");

endmodule

`default_nettype wire
